// ----- sv/ftwm_pkg.sv -----
// Package for the frame time window median block.
// Holds the sizes, operation codes and the scaler request and response types.
// No dependencies.
package ftwm_pkg;

  localparam int WINDOW = 100;
  localparam int ADDR_W = $clog2(WINDOW);
  localparam int IDX_W = $clog2(WINDOW + 1);
  localparam int CNT_W = 7;

  localparam int OP_W = 2;
  localparam int TICK_W = 64;
  localparam int DUR_W = 40;
  localparam int Q_W = 32;
  localparam int FRAC_W = 16;
  localparam int NS_W = 48;

  localparam int HALF_W = DUR_W / 2;
  localparam int PROD_W = HALF_W + Q_W;
  localparam int HI_SH = HALF_W - FRAC_W;
  localparam int SUM_W = PROD_W + HI_SH + 1;

  localparam logic [Q_W-1:0] Q_RESET = Q_W'(65536);

  localparam logic [OP_W-1:0] OP_RECORD = 2'd0;
  localparam logic [OP_W-1:0] OP_MEDIAN = 2'd1;
  localparam logic [OP_W-1:0] OP_LAST = 2'd2;
  localparam logic [OP_W-1:0] OP_PTR_RESET = 2'd3;

  typedef struct packed {
    logic start;
    logic [DUR_W-1:0] ticks;
  } scale_req_t;

  typedef struct packed {
    logic done;
    logic [NS_W-1:0] ns;
  } scale_rsp_t;

endpackage

// ----- sv/ftwm_cmd_if.sv -----
// Command channel of the frame time window median block.
// Carries one command word with valid and ready; uses ftwm_pkg.
interface ftwm_cmd_if import ftwm_pkg::*; ();
  logic valid;
  logic ready;
  logic [OP_W-1:0] operation;
  logic query_ok;
  logic [TICK_W-1:0] start_tick;
  logic [TICK_W-1:0] end_tick;

  modport source(output valid, operation, query_ok, start_tick, end_tick, input ready);
  modport sink(input valid, operation, query_ok, start_tick, end_tick, output ready);
endinterface

// ----- sv/ftwm_res_if.sv -----
// Result channel of the frame time window median block.
// Carries one result word with valid and ready; uses ftwm_pkg.
interface ftwm_res_if import ftwm_pkg::*; ();
  logic valid;
  logic ready;
  logic [NS_W-1:0] time_ns;
  logic [CNT_W-1:0] valid_count;

  modport source(output valid, time_ns, valid_count, input ready);
  modport sink(input valid, time_ns, valid_count, output ready);
endinterface

// ----- sv/ftwm_ram.sv -----
// Generic simple dual port RAM with one write port and a registered read port.
// Standalone; no package.
module ftwm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/ftwm_scale.sv -----
// Tick to nanosecond scaler: duration times an unsigned Q16.16 factor, saturated.
// One shared 20 by 32 bit multiplier used twice; uses ftwm_pkg.
module ftwm_scale import ftwm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [Q_W-1:0]   factor,
  input  scale_req_t       req,
  output scale_rsp_t       rsp
);

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_HI = 2'd1;
  localparam logic [1:0] P_LO = 2'd2;
  localparam logic [1:0] P_SUM = 2'd3;

  logic [1:0] phase;
  logic [DUR_W-1:0] ticks;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] hi_prod;
  logic [HALF_W-1:0] mul_a;
  logic [PROD_W-1:0] mul_p;
  logic [SUM_W-1:0] sum;
  logic done;
  logic [NS_W-1:0] ns;

  assign mul_a = (phase == P_HI) ? ticks[DUR_W-1:HALF_W] : ticks[HALF_W-1:0];
  assign mul_p = PROD_W'(mul_a) * PROD_W'(factor);
  assign sum = (SUM_W'(hi_prod) << HI_SH) + SUM_W'(prod >> FRAC_W);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        P_IDLE: begin
          if (req.start) begin
            ticks <= req.ticks;
            phase <= P_HI;
          end
        end
        P_HI: begin
          prod <= mul_p;
          phase <= P_LO;
        end
        P_LO: begin
          hi_prod <= prod;
          prod <= mul_p;
          phase <= P_SUM;
        end
        P_SUM: begin
          ns <= (|sum[SUM_W-1:NS_W]) ? {NS_W{1'b1}} : sum[NS_W-1:0];
          done <= 1'b1;
          phase <= P_IDLE;
        end
        default: begin
          phase <= P_IDLE;
        end
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.ns = ns;

endmodule

// ----- sv/frame_time_window_median.sv -----
// Top level of the frame time window median block.
// Uses ftwm_pkg, ftwm_cmd_if, ftwm_res_if, ftwm_ram and ftwm_scale.
//
//   port     kind           word
//   cmd      valid/ready    operation, query_ok, start_tick, end_tick
//   res      valid/ready    time_ns, valid_count
//   cfg      write enable   ns_per_tick_q16
//
// A record or pointer reset is done in the idle state. A last query reads the newest
// slot and scales it. A median query counts the window in one pass, then ranks
// candidates one at a time against the whole window through the single ring read
// port and one less-than and one less-or-equal comparison per entry read.
// Reset empties the ring at once through per-slot fill bits. The block takes no
// command while a query is in progress; a finished result waits in one output
// register, and the next query holds at its end until that result is taken.
module frame_time_window_median import ftwm_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [Q_W-1:0]  cfg_wdata,
  ftwm_cmd_if.sink        cmd,
  ftwm_res_if.source      res
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LAST = 4'd1;
  localparam logic [3:0] S_COUNT = 4'd2;
  localparam logic [3:0] S_CAND_RD = 4'd3;
  localparam logic [3:0] S_CAND = 4'd4;
  localparam logic [3:0] S_SCAN = 4'd5;
  localparam logic [3:0] S_SCALE_GO = 4'd6;
  localparam logic [3:0] S_SCALE_WAIT = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(WINDOW - 1);
  localparam logic [IDX_W-1:0] IDX_END = IDX_W'(WINDOW);

  logic [3:0] state;
  logic [Q_W-1:0] ns_per_tick_q16;
  logic [ADDR_W-1:0] write_pointer;
  logic [ADDR_W-1:0] excl;
  logic [WINDOW-1:0] filled;
  logic [IDX_W-1:0] idx;
  logic [ADDR_W-1:0] cidx;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] less;
  logic [CNT_W-1:0] leq;
  logic [DUR_W-1:0] cand;
  logic [DUR_W-1:0] ticks;
  logic [CNT_W-1:0] res_count;
  logic use_q;
  logic filled_q;
  logic res_valid;
  logic [NS_W-1:0] res_time;
  logic [CNT_W-1:0] res_cnt;

  logic accept;
  logic [TICK_W-1:0] delta;
  logic [DUR_W-1:0] delta_sat;
  logic [ADDR_W-1:0] wp_inc;
  logic rec_we;
  logic [ADDR_W-1:0] rd_addr;
  logic rd_use;
  logic [DUR_W-1:0] rdata;
  logic [DUR_W-1:0] value;
  logic live;
  logic is_less;
  logic is_leq;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] less_next;
  logic [CNT_W-1:0] leq_next;
  logic [CNT_W-1:0] rank;
  scale_req_t scale_req;
  scale_rsp_t scale_rsp;

  assign accept = cmd.valid && cmd.ready;
  assign cmd.ready = (state == S_IDLE);

  assign delta = cmd.end_tick - cmd.start_tick;
  assign delta_sat = (|delta[TICK_W-1:DUR_W]) ? {DUR_W{1'b1}} : delta[DUR_W-1:0];
  assign wp_inc = (write_pointer == LAST_SLOT) ? '0 : write_pointer + 1'b1;
  assign rec_we = accept && (cmd.operation == OP_RECORD) && cmd.query_ok;

  always_comb begin
    rd_addr = idx[ADDR_W-1:0];
    rd_use = 1'b0;
    unique case (state)
      S_IDLE: begin
        rd_addr = write_pointer;
      end
      S_COUNT, S_SCAN: begin
        rd_use = (idx != IDX_END) && (idx[ADDR_W-1:0] != excl);
      end
      S_CAND_RD: begin
        rd_addr = cidx;
        rd_use = (cidx != excl);
      end
      default: begin
        rd_use = 1'b0;
      end
    endcase
  end

  ftwm_ram #(
    .WIDTH(DUR_W),
    .DEPTH(WINDOW)
  ) u_ring (
    .clk(clk),
    .we(rec_we),
    .waddr(wp_inc),
    .wdata(delta_sat),
    .raddr(rd_addr),
    .rdata(rdata)
  );

  // A slot never written since reset reads as empty.
  assign value = filled_q ? rdata : '0;
  assign live = use_q && (value != '0);
  assign is_less = value < cand;
  assign is_leq = value <= cand;
  assign count_next = count + CNT_W'(live);
  assign less_next = less + CNT_W'(live && is_less);
  assign leq_next = leq + CNT_W'(live && is_leq);
  assign rank = count >> 1;

  assign scale_req.start = (state == S_SCALE_GO);
  assign scale_req.ticks = ticks;

  ftwm_scale u_scale (
    .clk(clk),
    .rst(rst),
    .factor(ns_per_tick_q16),
    .req(scale_req),
    .rsp(scale_rsp)
  );

  always_ff @(posedge clk) begin
    use_q <= rd_use;
    filled_q <= filled[rd_addr];
    if (rst) begin
      state <= S_IDLE;
      ns_per_tick_q16 <= Q_RESET;
      write_pointer <= LAST_SLOT;
      filled <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        ns_per_tick_q16 <= cfg_wdata;
      end
      if (res_valid && res.ready && (state != S_DONE)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (cmd.operation)
              OP_RECORD: begin
                if (cmd.query_ok) begin
                  write_pointer <= wp_inc;
                  filled[wp_inc] <= 1'b1;
                end
              end
              OP_MEDIAN: begin
                excl <= wp_inc;
                idx <= '0;
                count <= '0;
                state <= S_COUNT;
              end
              OP_LAST: begin
                state <= S_LAST;
              end
              OP_PTR_RESET: begin
                write_pointer <= LAST_SLOT;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_LAST: begin
          ticks <= value;
          res_count <= '0;
          state <= S_SCALE_GO;
        end
        S_COUNT: begin
          count <= count_next;
          if (idx == IDX_END) begin
            if (count_next == '0) begin
              ticks <= '0;
              res_count <= '0;
              state <= S_SCALE_GO;
            end else begin
              cidx <= '0;
              state <= S_CAND_RD;
            end
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_CAND_RD: begin
          state <= S_CAND;
        end
        S_CAND: begin
          if (live) begin
            cand <= value;
            idx <= '0;
            less <= '0;
            leq <= '0;
            state <= S_SCAN;
          end else begin
            cidx <= cidx + 1'b1;
            state <= S_CAND_RD;
          end
        end
        S_SCAN: begin
          less <= less_next;
          leq <= leq_next;
          if (idx == IDX_END) begin
            if ((less_next <= rank) && (rank < leq_next)) begin
              ticks <= cand;
              res_count <= count;
              state <= S_SCALE_GO;
            end else begin
              cidx <= cidx + 1'b1;
              state <= S_CAND_RD;
            end
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_SCALE_GO: begin
          state <= S_SCALE_WAIT;
        end
        S_SCALE_WAIT: begin
          if (scale_rsp.done) begin
            res_time <= scale_rsp.ns;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!res_valid || res.ready) begin
            res_valid <= 1'b1;
            res_cnt <= res_count;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!res_valid || res.ready)) begin
      res.time_ns <= res_time;
    end
  end

  assign res.valid = res_valid;
  assign res.valid_count = res_cnt;

endmodule

// ----- bench/frame_time_window_median_check.sv -----
// Checker for the frame time window median block: watches the command, result
// and configuration ports, keeps its own copy of the duration ring and scale,
// and compares every result word in order. Uses ftwm_pkg, ftwm_cmd_if, ftwm_res_if.
module frame_time_window_median_check import ftwm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [Q_W-1:0] cfg_wdata,
  ftwm_cmd_if cmd,
  ftwm_res_if res,
  output int fail_count,
  output int owed_count
);

  typedef struct packed {
    logic [NS_W-1:0] time_ns;
    logic [CNT_W-1:0] valid_count;
  } frame_time_t;

  logic [DUR_W-1:0] dur_ring [WINDOW];
  logic [ADDR_W-1:0] newest_slot;
  logic [Q_W-1:0] ns_scale;
  frame_time_t owed_times[$];
  int errors = 0;

  assign fail_count = errors;

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("Mismatch in %s at %0t: got %0d, expected %0d", what, $realtime, got, want);
    errors++;
  endtask

  function automatic logic [NS_W-1:0] ticks_to_ns(input logic [DUR_W-1:0] ticks);
    logic [DUR_W+Q_W-1:0] prod;
    prod = (DUR_W + Q_W)'(ticks) * (DUR_W + Q_W)'(ns_scale);
    prod = prod >> FRAC_W;
    if (prod[DUR_W+Q_W-1:NS_W] != '0) return '1;
    return prod[NS_W-1:0];
  endfunction

  function automatic frame_time_t window_median();
    logic [DUR_W-1:0] vals [WINDOW];
    logic [DUR_W-1:0] v;
    frame_time_t r;
    int n;
    int j;
    int k;
    n = 0;
    for (int i = 0; i < WINDOW - 1; i++) begin
      k = (int'(newest_slot) + WINDOW - i) % WINDOW;
      if (dur_ring[k] != '0) begin
        vals[n] = dur_ring[k];
        n++;
      end
    end
    r.time_ns = '0;
    r.valid_count = '0;
    if (n > 0) begin
      for (int i = 1; i < n; i++) begin
        v = vals[i];
        j = i;
        while (j > 0 && vals[j-1] > v) begin
          vals[j] = vals[j-1];
          j--;
        end
        vals[j] = v;
      end
      r.time_ns = ticks_to_ns(vals[n/2]);
      r.valid_count = CNT_W'(n);
    end
    return r;
  endfunction

  task automatic apply_word(input logic [OP_W-1:0] op, input logic ok,
                            input logic [TICK_W-1:0] start_t, input logic [TICK_W-1:0] end_t);
    logic [TICK_W-1:0] delta;
    frame_time_t r;
    case (op)
      OP_RECORD: begin
        if (ok) begin
          delta = end_t - start_t;
          newest_slot = (newest_slot == ADDR_W'(WINDOW - 1)) ? '0 : newest_slot + 1'b1;
          dur_ring[newest_slot] = (delta[TICK_W-1:DUR_W] != '0) ? '1 : delta[DUR_W-1:0];
        end
      end
      OP_PTR_RESET: begin
        newest_slot = ADDR_W'(WINDOW - 1);
      end
      OP_LAST: begin
        r.time_ns = ticks_to_ns(dur_ring[newest_slot]);
        r.valid_count = '0;
        owed_times.push_back(r);
      end
      default: begin
        owed_times.push_back(window_median());
      end
    endcase
  endtask

  always @(posedge clk) begin
    frame_time_t want;
    if (rst) begin
      for (int i = 0; i < WINDOW; i++) dur_ring[i] = '0;
      newest_slot = ADDR_W'(WINDOW - 1);
      ns_scale = Q_RESET;
      owed_times.delete();
    end else begin
      if (cfg_we) ns_scale = cfg_wdata;
      if (res.valid && res.ready) begin
        if (owed_times.size() == 0) begin
          flag_mismatch("result with nothing pending", 64'(res.time_ns), 64'd0);
        end else begin
          want = owed_times.pop_front();
          if (res.time_ns !== want.time_ns)
            flag_mismatch("time_ns", 64'(res.time_ns), 64'(want.time_ns));
          if (res.valid_count !== want.valid_count)
            flag_mismatch("valid_count", 64'(res.valid_count), 64'(want.valid_count));
        end
      end
      if (cmd.valid && cmd.ready)
        apply_word(cmd.operation, cmd.query_ok, cmd.start_tick, cmd.end_tick);
    end
    owed_count <= owed_times.size();
  end

endmodule

// ----- bench/frame_time_window_median_tb.sv -----
// Testbench top for the frame time window median block: drives directed and
// random command words, result back-pressure and scale writes, and gives the verdict.
// Uses ftwm_pkg, ftwm_cmd_if, ftwm_res_if and frame_time_window_median_check.
module frame_time_window_median_tb;
  import ftwm_pkg::*;

  localparam int STALL_LIMIT = 60000;
  localparam int SETTLE = 20;
  localparam int LONG_HOLD = 12000;
  localparam int PHASES = 4;
  localparam int PHASE_WORDS = 20;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [Q_W-1:0] cfg_wdata;
  logic calm_tail;
  int hold_asks = 0;
  int fail_count;
  int owed_count;
  int quiet_cycles = 0;
  int src_calm_left = 0;

  ftwm_cmd_if cmd_ch();
  ftwm_res_if res_ch();

  frame_time_window_median i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .cmd(cmd_ch),
    .res(res_ch)
  );

  frame_time_window_median_check u_check (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .cmd(cmd_ch),
    .res(res_ch),
    .fail_count(fail_count),
    .owed_count(owed_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : result_sink
    int calm_left;
    int holds_taken;
    calm_left = 0;
    holds_taken = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (calm_left > 0) calm_left--;
      else if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(40, 200);
      if (hold_asks != holds_taken) begin
        holds_taken = hold_asks;
        res_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm_tail && calm_left == 0 && $urandom_range(0, 4) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
    end
  end

  task automatic send_word(input logic [OP_W-1:0] op, input logic ok,
                           input logic [TICK_W-1:0] start_t, input logic [TICK_W-1:0] end_t);
    if (src_calm_left > 0) begin
      src_calm_left--;
    end else if ($urandom_range(0, 9) == 0) begin
      src_calm_left = $urandom_range(10, 30);
    end else if (!calm_tail && $urandom_range(0, 3) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.operation <= op;
    cmd_ch.query_ok <= ok;
    cmd_ch.start_tick <= start_t;
    cmd_ch.end_tick <= end_t;
    do @(posedge clk); while (!cmd_ch.ready);
  endtask

  task automatic wait_idle();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (owed_count != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_scale(input logic [Q_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_random_word();
    logic [TICK_W-1:0] s;
    logic [TICK_W-1:0] e;
    logic [TICK_W-1:0] d;
    int pick;
    s = {$urandom, $urandom};
    e = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: d = '0;
      1: d = TICK_W'(64'h100_0000_0000 - 2 + $urandom_range(0, 3));
      2: d = e - s;
      3, 4, 5: d = TICK_W'($urandom_range(1, 16));
      default: d = {24'd0, 8'($urandom), 32'($urandom)};
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 55) send_word(OP_RECORD, 1'b1, s, s + d);
    else if (pick < 62) send_word(OP_RECORD, 1'b0, s, e);
    else if (pick < 80) send_word(OP_MEDIAN, 1'($urandom), s, e);
    else if (pick < 94) send_word(OP_LAST, 1'($urandom), s, e);
    else send_word(OP_PTR_RESET, 1'($urandom), s, e);
  endtask

  initial begin : stimulus
    logic [Q_W-1:0] scale;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    calm_tail <= 1'b0;
    cmd_ch.valid <= 1'b0;
    cmd_ch.operation <= OP_RECORD;
    cmd_ch.query_ok <= 1'b0;
    cmd_ch.start_tick <= '0;
    cmd_ch.end_tick <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_word(OP_MEDIAN, 1'b1, '1, '1);
    send_word(OP_LAST, 1'b0, '0, '0);
    send_word(OP_RECORD, 1'b1, 64'd5, 64'd5);
    send_word(OP_LAST, 1'b1, '0, '1);
    send_word(OP_RECORD, 1'b1, 64'd100, 64'd1100);
    send_word(OP_RECORD, 1'b0, '0, '1);
    send_word(OP_LAST, 1'b0, '1, '0);
    send_word(OP_RECORD, 1'b1, '1, 64'd5);
    send_word(OP_RECORD, 1'b1, '0, '1);
    send_word(OP_RECORD, 1'b1, 64'd0, 64'hFF_FFFF_FFFF);
    send_word(OP_RECORD, 1'b1, 64'd0, 64'h100_0000_0000);
    send_word(OP_RECORD, 1'b1, 64'd7, 64'd1007);
    send_word(OP_RECORD, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA + 64'd1000);
    send_word(OP_MEDIAN, 1'b0, '0, '0);
    send_word(OP_PTR_RESET, 1'b1, '1, '1);
    send_word(OP_RECORD, 1'b1, 64'd0, 64'd77);
    send_word(OP_MEDIAN, 1'b1, 64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555);
    send_word(OP_LAST, 1'b1, '0, '0);
    wait_idle();

    set_scale('1);
    send_word(OP_LAST, 1'b0, '0, '0);
    send_word(OP_RECORD, 1'b1, '0, '1);
    send_word(OP_LAST, 1'b0, '0, '0);
    send_word(OP_MEDIAN, 1'b0, '0, '0);
    wait_idle();

    set_scale('0);
    send_word(OP_MEDIAN, 1'b0, '0, '0);
    send_word(OP_LAST, 1'b0, '0, '0);
    wait_idle();

    set_scale(Q_W'(1));
    send_word(OP_MEDIAN, 1'b0, '0, '0);
    send_word(OP_LAST, 1'b0, '0, '0);
    wait_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      case ($urandom_range(0, 4))
        0: scale = Q_W'(1);
        1: scale = '1;
        2: scale = Q_RESET;
        3: scale = Q_W'($urandom_range(1, 1 << 20));
        default: scale = Q_W'($urandom);
      endcase
      if (scale == '0) scale = Q_RESET;
      set_scale(scale);
      if (ph == PHASES - 1) calm_tail <= 1'b1;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (ph == 1 && n == 4) hold_asks <= hold_asks + 1;
        send_random_word();
      end
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/ftwm_pkg.sv
sv/ftwm_cmd_if.sv
sv/ftwm_res_if.sv
sv/ftwm_ram.sv
sv/ftwm_scale.sv
sv/frame_time_window_median.sv
bench/frame_time_window_median_check.sv
bench/frame_time_window_median_tb.sv
